@@ sv/lavm_pkg.sv @@
// Shared types and constants for the look-at view matrix block.
// Holds the Q-format word, the vector and item structs and pipeline latencies.
// No dependencies.
`default_nettype none

package lavm_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    // Normalizer depth: magnitude, max, scale, square, sum, root, prep, divide, sign.
    localparam int NRM_LAT   = 5 + WORD_BITS / 2 + 1 + (FRAC_BITS + 2) / 2 + 1;
    // Whole block: diff stage, two normalizers, two cross stages, four tail stages.
    localparam int LATENCY   = 2 * NRM_LAT + 7;
    localparam int ONE_Q     = 1 << FRAC_BITS;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef t_word [2:0] t_vec;

    typedef struct packed {
        t_word eye_x;
        t_word eye_y;
        t_word eye_z;
        t_word target_x;
        t_word target_y;
        t_word target_z;
        t_word upvec_x;
        t_word upvec_y;
        t_word upvec_z;
    } t_in;

    typedef struct packed {
        t_word side_x;
        t_word side_y;
        t_word side_z;
        t_word true_up_x;
        t_word true_up_y;
        t_word true_up_z;
        t_word back_x;
        t_word back_y;
        t_word back_z;
        t_word shift_x;
        t_word shift_y;
        t_word shift_z;
    } t_out;

endpackage

`default_nettype wire

@@ sv/lavm_norm.sv @@
// Pipelined 3-vector normalizer: scale, sum of squares, square root, divide.
// Takes one vector per cycle.
// Depends on lavm_pkg.
`default_nettype none

module lavm_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  lavm_pkg::t_vec i_vec,
    output logic          o_valid,
    output lavm_pkg::t_vec o_vec
);

    localparam int W     = lavm_pkg::WORD_BITS;
    localparam int F     = lavm_pkg::FRAC_BITS;
    localparam int SW    = 2 * W;
    localparam int RW    = W + 4;
    localparam int SH_W  = $clog2(W);
    localparam int SQ_ST = W / 2;
    localparam int DW    = W + F + 2;
    localparam int QW    = F + 2;
    localparam int DV_ST = QW / 2;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } t_flag;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [W-1:0]  root;
        logic [SW-1:0] s;
    } t_sq;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] q;
    } t_dv;

    // One root bit: bring down two radicand bits, try root*4+1.
    function automatic t_sq sq_step(input t_sq a);
        t_sq           b;
        logic [RW-1:0] r2;
        logic [RW-1:0] trial;
        r2    = {a.rem[RW-3:0], a.s[SW-1:SW-2]};
        trial = RW'({a.root, 2'b01});
        b.s   = a.s << 2;
        if (r2 >= trial) begin
            b.rem  = r2 - trial;
            b.root = {a.root[W-2:0], 1'b1};
        end else begin
            b.rem  = r2;
            b.root = {a.root[W-2:0], 1'b0};
        end
        return b;
    endfunction

    // One quotient bit at weight 2^k.
    function automatic t_dv dv_step(input t_dv a, input logic [W-1:0] n, input int k);
        t_dv           b;
        logic [DW-1:0] d;
        d = DW'(n) << k;
        b = a;
        if (a.rem >= d) begin
            b.rem = a.rem - d;
            b.q   = a.q | (QW'(1) << k);
        end
        return b;
    endfunction

    // Stage A: magnitudes
    logic [W-1:0]   r_a_mag [3];
    logic [2:0]     r_a_neg;
    logic           r_a_vld;
    // Stage B: largest magnitude
    logic [W-1:0]   r_b_mag [3];
    logic [W-1:0]   r_b_top;
    logic [2:0]     r_b_neg;
    logic           r_b_vld;
    // Stage C: common scaling
    logic [W-2:0]   r_c_m [3];
    t_flag          r_c_flg;
    logic           r_c_vld;
    // Stage D: squares
    logic [SW-3:0]  r_d_sq [3];
    logic [W-2:0]   r_d_m [3];
    t_flag          r_d_flg;
    logic           r_d_vld;
    // Stage E: sum of squares
    logic [SW-1:0]  r_e_sum;
    logic [W-2:0]   r_e_m [3];
    t_flag          r_e_flg;
    logic           r_e_vld;
    // Square root pipe
    t_sq            r_sq [SQ_ST];
    logic [W-2:0]   r_sq_m [SQ_ST][3];
    t_flag          r_sq_flg [SQ_ST];
    logic           r_sq_vld [SQ_ST];
    t_sq            n_sq [SQ_ST];
    // Divide prep
    logic [DW-1:0]  r_p_dnd [3];
    logic [W-1:0]   r_p_n;
    t_flag          r_p_flg;
    logic           r_p_vld;
    // Divide pipe
    t_dv            r_dv [DV_ST][3];
    logic [W-1:0]   r_dv_n [DV_ST];
    t_flag          r_dv_flg [DV_ST];
    logic           r_dv_vld [DV_ST];
    t_dv            n_dv [DV_ST][3];
    // Output
    lavm_pkg::t_vec r_o_vec;
    logic           r_o_vld;

    logic [SH_W-1:0] n_c_msb;
    logic [SH_W-1:0] n_c_sh;

    always_comb begin
        n_c_msb = '0;
        for (int i = 0; i < W; i++) begin
            if (r_b_top[i]) n_c_msb = SH_W'(i);
        end
        n_c_sh = SH_W'(W - 2) - n_c_msb;
    end

    always_comb begin
        t_sq src;
        for (int k = 0; k < SQ_ST; k++) begin
            if (k == 0) begin
                src = '{rem: '0, root: '0, s: r_e_sum};
            end else begin
                src = r_sq[k-1];
            end
            n_sq[k] = sq_step(sq_step(src));
        end
    end

    always_comb begin
        t_dv          src;
        logic [W-1:0] n;
        for (int j = 0; j < DV_ST; j++) begin
            n = (j == 0) ? r_p_n : r_dv_n[j-1];
            for (int i = 0; i < 3; i++) begin
                if (j == 0) begin
                    src = '{rem: r_p_dnd[i], q: '0};
                end else begin
                    src = r_dv[j-1][i];
                end
                n_dv[j][i] = dv_step(dv_step(src, n, QW - 1 - 2 * j), n, QW - 2 - 2 * j);
            end
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
            for (int k = 0; k < SQ_ST; k++) r_sq_vld[k] <= 1'b0;
            for (int j = 0; j < DV_ST; j++) r_dv_vld[j] <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_sq_vld[0] <= r_e_vld;
            for (int k = 1; k < SQ_ST; k++) r_sq_vld[k] <= r_sq_vld[k-1];
            r_p_vld <= r_sq_vld[SQ_ST-1];
            r_dv_vld[0] <= r_p_vld;
            for (int j = 1; j < DV_ST; j++) r_dv_vld[j] <= r_dv_vld[j-1];
            r_o_vld <= r_dv_vld[DV_ST-1];
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_mag[i] <= i_vec[i][W-1] ? W'(-i_vec[i]) : W'(i_vec[i]);
            r_a_neg[i] <= i_vec[i][W-1];
        end

        r_b_mag <= r_a_mag;
        r_b_neg <= r_a_neg;
        if (r_a_mag[0] >= r_a_mag[1] && r_a_mag[0] >= r_a_mag[2]) begin
            r_b_top <= r_a_mag[0];
        end else if (r_a_mag[1] >= r_a_mag[2]) begin
            r_b_top <= r_a_mag[1];
        end else begin
            r_b_top <= r_a_mag[2];
        end

        // Bring the largest magnitude into [2^(W-2), 2^(W-1)).
        for (int i = 0; i < 3; i++) begin
            if (r_b_top[W-1]) begin
                r_c_m[i] <= (W-1)'(r_b_mag[i] >> 1);
            end else begin
                r_c_m[i] <= (W-1)'(r_b_mag[i] << n_c_sh);
            end
        end
        r_c_flg.neg  <= r_b_neg;
        r_c_flg.zero <= (r_b_top == '0);

        for (int i = 0; i < 3; i++) begin
            r_d_sq[i] <= (SW-2)'(r_c_m[i]) * (SW-2)'(r_c_m[i]);
        end
        r_d_m   <= r_c_m;
        r_d_flg <= r_c_flg;

        r_e_sum <= SW'(r_d_sq[0]) + SW'(r_d_sq[1]) + SW'(r_d_sq[2]);
        r_e_m   <= r_d_m;
        r_e_flg <= r_d_flg;

        for (int k = 0; k < SQ_ST; k++) r_sq[k] <= n_sq[k];
        r_sq_m[0]   <= r_e_m;
        r_sq_flg[0] <= r_e_flg;
        for (int k = 1; k < SQ_ST; k++) begin
            r_sq_m[k]   <= r_sq_m[k-1];
            r_sq_flg[k] <= r_sq_flg[k-1];
        end

        // Dividend carries half the divisor for round half away from zero.
        for (int i = 0; i < 3; i++) begin
            r_p_dnd[i] <= (DW'(r_sq_m[SQ_ST-1][i]) << F) + DW'(r_sq[SQ_ST-1].root >> 1);
        end
        r_p_n   <= r_sq[SQ_ST-1].root;
        r_p_flg <= r_sq_flg[SQ_ST-1];

        for (int j = 0; j < DV_ST; j++) r_dv[j] <= n_dv[j];
        r_dv_n[0]   <= r_p_n;
        r_dv_flg[0] <= r_p_flg;
        for (int j = 1; j < DV_ST; j++) begin
            r_dv_n[j]   <= r_dv_n[j-1];
            r_dv_flg[j] <= r_dv_flg[j-1];
        end

        // Zero-length vector passes through as zero.
        for (int i = 0; i < 3; i++) begin
            if (r_dv_flg[DV_ST-1].zero) begin
                r_o_vec[i] <= '0;
            end else if (r_dv_flg[DV_ST-1].neg[i]) begin
                r_o_vec[i] <= -W'(r_dv[DV_ST-1][i].q);
            end else begin
                r_o_vec[i] <= W'(r_dv[DV_ST-1][i].q);
            end
        end
    end

    assign o_valid = r_o_vld;
    assign o_vec   = r_o_vec;

endmodule

`default_nettype wire

@@ sv/look_at_view_matrix.sv @@
// Throughput: one item per cycle; busy stays low, each stage is a plain register.
// Most of the depth lies in the two normalizers, each a 16-stage square root and a
// 9-stage divider, two quotient or root bits per stage.
// Reset (synchronous, active low) clears valid bits only; items in flight are dropped.
// Depends on lavm_pkg and lavm_norm.
`default_nettype none

module look_at_view_matrix (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  lavm_pkg::t_in  i_item,
    output logic           o_done,
    output lavm_pkg::t_out o_result
);

    localparam int W  = lavm_pkg::WORD_BITS;
    localparam int F  = lavm_pkg::FRAC_BITS;
    localparam int L  = lavm_pkg::NRM_LAT;
    localparam int PW = 2 * W;
    localparam int XW = PW + 3;

    localparam lavm_pkg::t_word W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam lavm_pkg::t_word W_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [XW-1:0] X_MAX = XW'(W_MAX);
    localparam logic signed [XW-1:0] X_MIN = XW'(W_MIN);
    localparam logic signed [XW-1:0] HALF  = XW'(1) << (F - 1);

    // Round half toward plus infinity at the binary point, then saturate.
    function automatic lavm_pkg::t_word rnd_sat(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] t;
        t = (x + HALF) >>> F;
        if (t > X_MAX) begin
            return W_MAX;
        end else if (t < X_MIN) begin
            return W_MIN;
        end
        return t[W-1:0];
    endfunction

    // Item enters with start: the pipeline never holds.
    assign busy = 1'b0;

    // Stage P1: forward = target - eye, saturated
    logic                  r_p1_vld;
    lavm_pkg::t_vec        r_p1_fwd;
    lavm_pkg::t_vec        r_p1_eye;
    lavm_pkg::t_vec        r_p1_upv;
    lavm_pkg::t_vec        n_p1_fwd;
    lavm_pkg::t_vec        n_eye;
    lavm_pkg::t_vec        n_tgt;
    lavm_pkg::t_vec        n_upv;

    always_comb begin
        logic signed [W:0] d;
        n_eye = {i_item.eye_z, i_item.eye_y, i_item.eye_x};
        n_tgt = {i_item.target_z, i_item.target_y, i_item.target_x};
        n_upv = {i_item.upvec_z, i_item.upvec_y, i_item.upvec_x};
        for (int i = 0; i < 3; i++) begin
            d = (W+1)'(n_tgt[i]) - (W+1)'(n_eye[i]);
            if (d[W] != d[W-1]) begin
                n_p1_fwd[i] = d[W] ? W_MIN : W_MAX;
            end else begin
                n_p1_fwd[i] = d[W-1:0];
            end
        end
    end

    // First normalizer: forward
    logic           w_n1_vld;
    lavm_pkg::t_vec w_n1_vec;

    lavm_norm u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p1_vld),
        .i_vec   (r_p1_fwd),
        .o_valid (w_n1_vld),
        .o_vec   (w_n1_vec)
    );

    // Hold eye and up alongside the first normalizer
    lavm_pkg::t_vec r_d1_eye [L];
    lavm_pkg::t_vec r_d1_upv [L];

    // Stage X1: products of forward x up
    logic                  r_x1_vld;
    logic signed [PW-1:0]  r_x1_prd [6];
    lavm_pkg::t_vec        r_x1_fwd;
    lavm_pkg::t_vec        r_x1_eye;

    // Stage X2: side, rounded and saturated
    logic                  r_x2_vld;
    lavm_pkg::t_vec        r_x2_side;
    lavm_pkg::t_vec        r_x2_fwd;
    lavm_pkg::t_vec        r_x2_eye;

    // Second normalizer: side
    logic           w_n2_vld;
    lavm_pkg::t_vec w_n2_vec;

    lavm_norm u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_x2_vld),
        .i_vec   (r_x2_side),
        .o_valid (w_n2_vld),
        .o_vec   (w_n2_vec)
    );

    // Hold forward and eye alongside the second normalizer
    lavm_pkg::t_vec r_d2_fwd [L];
    lavm_pkg::t_vec r_d2_eye [L];

    // Stage Y1: side x forward products, side.eye and forward.eye products
    logic                  r_y1_vld;
    logic signed [PW-1:0]  r_y1_prd [6];
    logic signed [PW-1:0]  r_y1_pse [3];
    logic signed [PW-1:0]  r_y1_pfe [3];
    lavm_pkg::t_vec        r_y1_side;
    lavm_pkg::t_vec        r_y1_fwd;
    lavm_pkg::t_vec        r_y1_eye;

    // Stage Y2: true up, two translation terms
    logic                  r_y2_vld;
    lavm_pkg::t_vec        r_y2_up;
    lavm_pkg::t_word       r_y2_ds;
    lavm_pkg::t_word       r_y2_df;
    lavm_pkg::t_vec        r_y2_side;
    lavm_pkg::t_vec        r_y2_fwd;
    lavm_pkg::t_vec        r_y2_eye;

    // Stage Y3: up.eye products
    logic                  r_y3_vld;
    logic signed [PW-1:0]  r_y3_pue [3];
    lavm_pkg::t_vec        r_y3_up;
    lavm_pkg::t_word       r_y3_ds;
    lavm_pkg::t_word       r_y3_df;
    lavm_pkg::t_vec        r_y3_side;
    lavm_pkg::t_vec        r_y3_fwd;

    // Stage Y4: output register
    logic                  r_y4_vld;
    lavm_pkg::t_out        r_y4;
    lavm_pkg::t_out        n_y4;

    always_comb begin
        n_y4.side_x    = r_y3_side[0];
        n_y4.side_y    = r_y3_side[1];
        n_y4.side_z    = r_y3_side[2];
        n_y4.true_up_x = r_y3_up[0];
        n_y4.true_up_y = r_y3_up[1];
        n_y4.true_up_z = r_y3_up[2];
        // Normalized forward lies within one, so negation cannot overflow.
        n_y4.back_x    = -r_y3_fwd[0];
        n_y4.back_y    = -r_y3_fwd[1];
        n_y4.back_z    = -r_y3_fwd[2];
        n_y4.shift_x   = r_y3_ds;
        n_y4.shift_y   = rnd_sat(-(XW'(r_y3_pue[0]) + XW'(r_y3_pue[1]) + XW'(r_y3_pue[2])));
        n_y4.shift_z   = r_y3_df;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_x1_vld <= 1'b0;
            r_x2_vld <= 1'b0;
            r_y1_vld <= 1'b0;
            r_y2_vld <= 1'b0;
            r_y3_vld <= 1'b0;
            r_y4_vld <= 1'b0;
        end else begin
            r_p1_vld <= start && !busy;
            r_x1_vld <= w_n1_vld;
            r_x2_vld <= r_x1_vld;
            r_y1_vld <= w_n2_vld;
            r_y2_vld <= r_y1_vld;
            r_y3_vld <= r_y2_vld;
            r_y4_vld <= r_y3_vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_p1_fwd <= n_p1_fwd;
        r_p1_eye <= n_eye;
        r_p1_upv <= n_upv;

        r_d1_eye[0] <= r_p1_eye;
        r_d1_upv[0] <= r_p1_upv;
        for (int k = 1; k < L; k++) begin
            r_d1_eye[k] <= r_d1_eye[k-1];
            r_d1_upv[k] <= r_d1_upv[k-1];
        end

        // side = forward x up
        r_x1_prd[0] <= PW'(w_n1_vec[1]) * PW'(r_d1_upv[L-1][2]);
        r_x1_prd[1] <= PW'(w_n1_vec[2]) * PW'(r_d1_upv[L-1][1]);
        r_x1_prd[2] <= PW'(w_n1_vec[2]) * PW'(r_d1_upv[L-1][0]);
        r_x1_prd[3] <= PW'(w_n1_vec[0]) * PW'(r_d1_upv[L-1][2]);
        r_x1_prd[4] <= PW'(w_n1_vec[0]) * PW'(r_d1_upv[L-1][1]);
        r_x1_prd[5] <= PW'(w_n1_vec[1]) * PW'(r_d1_upv[L-1][0]);
        r_x1_fwd    <= w_n1_vec;
        r_x1_eye    <= r_d1_eye[L-1];

        for (int i = 0; i < 3; i++) begin
            r_x2_side[i] <= rnd_sat(XW'(r_x1_prd[2*i]) - XW'(r_x1_prd[2*i+1]));
        end
        r_x2_fwd <= r_x1_fwd;
        r_x2_eye <= r_x1_eye;

        r_d2_fwd[0] <= r_x2_fwd;
        r_d2_eye[0] <= r_x2_eye;
        for (int k = 1; k < L; k++) begin
            r_d2_fwd[k] <= r_d2_fwd[k-1];
            r_d2_eye[k] <= r_d2_eye[k-1];
        end

        // true up = side x forward
        r_y1_prd[0] <= PW'(w_n2_vec[1]) * PW'(r_d2_fwd[L-1][2]);
        r_y1_prd[1] <= PW'(w_n2_vec[2]) * PW'(r_d2_fwd[L-1][1]);
        r_y1_prd[2] <= PW'(w_n2_vec[2]) * PW'(r_d2_fwd[L-1][0]);
        r_y1_prd[3] <= PW'(w_n2_vec[0]) * PW'(r_d2_fwd[L-1][2]);
        r_y1_prd[4] <= PW'(w_n2_vec[0]) * PW'(r_d2_fwd[L-1][1]);
        r_y1_prd[5] <= PW'(w_n2_vec[1]) * PW'(r_d2_fwd[L-1][0]);
        for (int i = 0; i < 3; i++) begin
            r_y1_pse[i] <= PW'(w_n2_vec[i]) * PW'(r_d2_eye[L-1][i]);
            r_y1_pfe[i] <= PW'(r_d2_fwd[L-1][i]) * PW'(r_d2_eye[L-1][i]);
        end
        r_y1_side <= w_n2_vec;
        r_y1_fwd  <= r_d2_fwd[L-1];
        r_y1_eye  <= r_d2_eye[L-1];

        for (int i = 0; i < 3; i++) begin
            r_y2_up[i] <= rnd_sat(XW'(r_y1_prd[2*i]) - XW'(r_y1_prd[2*i+1]));
        end
        r_y2_ds   <= rnd_sat(-(XW'(r_y1_pse[0]) + XW'(r_y1_pse[1]) + XW'(r_y1_pse[2])));
        r_y2_df   <= rnd_sat(XW'(r_y1_pfe[0]) + XW'(r_y1_pfe[1]) + XW'(r_y1_pfe[2]));
        r_y2_side <= r_y1_side;
        r_y2_fwd  <= r_y1_fwd;
        r_y2_eye  <= r_y1_eye;

        for (int i = 0; i < 3; i++) begin
            r_y3_pue[i] <= PW'(r_y2_up[i]) * PW'(r_y2_eye[i]);
        end
        r_y3_up   <= r_y2_up;
        r_y3_ds   <= r_y2_ds;
        r_y3_df   <= r_y2_df;
        r_y3_side <= r_y2_side;
        r_y3_fwd  <= r_y2_fwd;

        r_y4 <= n_y4;
    end

    assign o_done   = r_y4_vld;
    assign o_result = r_y4;

endmodule

`default_nettype wire

@@ sv/lavm_checker.sv @@
// Port-level checker for look_at_view_matrix, bound to the top level.
// Checks that busy stays low, fixed latency, result origin and properties of the rows.
// Depends on lavm_pkg.
`default_nettype none

module lavm_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire lavm_pkg::t_in  i_item,
    input wire logic           o_done,
    input wire lavm_pkg::t_out o_result
);

    a_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##(lavm_pkg::LATENCY) o_done)
        else $error("item result missing at fixed latency");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, lavm_pkg::LATENCY))
        else $error("result without an item");

    a_back_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.back_x <= lavm_pkg::ONE_Q && o_result.back_x >= -lavm_pkg::ONE_Q
                && o_result.back_y <= lavm_pkg::ONE_Q && o_result.back_y >= -lavm_pkg::ONE_Q
                && o_result.back_z <= lavm_pkg::ONE_Q && o_result.back_z >= -lavm_pkg::ONE_Q)
        else $error("forward row above unit length");

    a_zero_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.back_x == 0 && o_result.back_y == 0 && o_result.back_z == 0
        |-> o_result.side_x == 0 && o_result.side_y == 0 && o_result.side_z == 0)
        else $error("side row not zero for zero forward");

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (.*);

`default_nettype wire
